// File: design/assert_macros.svh
// Assertion macros used by the pin change event queue core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition in one cycle brings a consequence in the next
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");

`endif

// File: design/pcq_pkg.sv
// Shared types and constants for the pin change event queue
package pcq_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int PIN_COUNT     = 5;
    localparam int ENTRY_W       = 64;
    localparam int CMD_W         = 2;
    localparam int FREE_W        = 8;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

    localparam logic [15:0] EVENT_CODE  = 16'h0001;
    localparam int          EVENT_SHIFT = 16;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [ENTRY_W-1:0]   entry_in;
        logic [PIN_COUNT-1:0] pin_levels;
    } t_item;

    typedef struct packed {
        logic              pop_valid;
        logic [FREE_W-1:0] free_space;
        logic              attention_line;
        logic              overflow;
    } t_result;

endpackage

// File: design/pcq_ram.sv
// Generic single write port RAM with registered read
module pcq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pcq_engine.sv
// Queue pointers, pin change detection and entry store access
module pcq_engine #(
    parameter int DEPTH = pcq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcq_pkg::PIN_COUNT-1:0]     i_cfg_wdata,
    input  logic                              i_fire,
    input  pcq_pkg::t_item                    i_item,
    output pcq_pkg::t_result                  o_res,
    output logic [pcq_pkg::ENTRY_W-1:0]       o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH - 1);

    logic [AW-1:0]                 r_wr_idx, n_wr_idx;
    logic [AW-1:0]                 r_rd_idx, n_rd_idx;
    logic [pcq_pkg::PIN_COUNT-1:0] r_prev_pins, n_prev_pins;
    logic                          r_line, n_line;
    logic [pcq_pkg::PIN_COUNT-1:0] r_mask;

    logic [CW-1:0]                 w_held, w_held_after;
    logic                          w_full, w_empty;
    logic [pcq_pkg::PIN_COUNT-1:0] w_changes;
    logic                          w_do_enq, w_enq_ok, w_pop_ok, w_drop;
    logic [pcq_pkg::ENTRY_W-1:0]   w_enq_data;
    logic [pcq_pkg::FREE_W-1:0]    w_free;

    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            w_held = CW'(r_wr_idx) - CW'(r_rd_idx);
        end else begin
            w_held = CW'(r_wr_idx) + CW'(DEPTH) - CW'(r_rd_idx);
        end
    end

    assign w_full    = (w_held >= FULL_CNT);
    assign w_empty   = (r_wr_idx == r_rd_idx);
    assign w_changes = (i_item.pin_levels ^ r_prev_pins) & r_mask;

    assign w_do_enq = (i_item.command == pcq_pkg::CMD_PUSH) ||
                      ((i_item.command == pcq_pkg::CMD_TICK) && (w_changes != '0));
    assign w_enq_ok = w_do_enq && !w_full;
    assign w_drop   = w_do_enq && w_full;
    assign w_pop_ok = (i_item.command == pcq_pkg::CMD_POP) && !w_empty;

    assign w_enq_data = (i_item.command == pcq_pkg::CMD_PUSH) ? i_item.entry_in :
                        ((pcq_pkg::ENTRY_W'(w_changes) << pcq_pkg::EVENT_SHIFT) |
                         pcq_pkg::ENTRY_W'(pcq_pkg::EVENT_CODE));

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_prev_pins = r_prev_pins;
        n_line      = r_line;
        if (w_enq_ok) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
            n_line   = 1'b0;
        end
        if (i_item.command == pcq_pkg::CMD_TICK) begin
            n_prev_pins = i_item.pin_levels;
        end
        if (i_item.command == pcq_pkg::CMD_POP) begin
            if (w_empty) begin
                n_line = 1'b1;
            end else begin
                n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                n_line   = 1'b0;
            end
        end
    end

    assign w_held_after = w_held + CW'(w_enq_ok) - CW'(w_pop_ok);
    assign w_free       = pcq_pkg::FREE_W'(DEPTH) - pcq_pkg::FREE_W'(w_held_after);

    always_comb begin
        o_res.pop_valid      = w_pop_ok;
        o_res.free_space     = w_free;
        o_res.attention_line = n_line;
        o_res.overflow       = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_prev_pins <= '0;
            r_line      <= 1'b1;
            r_mask      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_wr_idx    <= n_wr_idx;
                r_rd_idx    <= n_rd_idx;
                r_prev_pins <= n_prev_pins;
                r_line      <= n_line;
            end
        end
    end

    pcq_ram #(
        .WIDTH (pcq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_fire && w_enq_ok),
        .i_waddr (r_wr_idx),
        .i_wdata (w_enq_data),
        .i_re    (i_fire && w_pop_ok),
        .i_raddr (r_rd_idx),
        .o_rdata (o_rdata)
    );

endmodule

// File: design/pin_change_event_queue_core.sv
// Pin change event queue: stream ports, input and result registers
//
// Input transactions carry a command in i_s_tuser (push, pin sample tick,
// pop) and the entry and pin levels in i_s_tdata. Each accepted
// transaction yields exactly one result transaction on the master side
// with the popped entry, free space, attention line and overflow flag.
// o_m_tvalid rises once the transaction has passed the input register and
// the result register; one transaction per cycle is sustained while the
// receiver does not stall, with the single entry store access and pointer
// update done between the input and result registers.
// User must write the change mask via i_cfg_we/i_cfg_wdata only while idle; unchecked.
// Reset empties the queue, clears the mask and previous pin levels and
// raises the attention line; the entry store is not cleared, so no
// clearing pass is needed. When the receiver stalls, the result is held
// and one more transaction is taken into the input register, after which
// o_s_tready drops until the result is taken.
`include "assert_macros.svh"

module pin_change_event_queue_core #(
    parameter int DEPTH = pcq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // entry_in[63:0], pin_levels[68:64], zero pad
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // pop_valid[0], entry_out[64:1], free_space[72:65],
                                     // attention_line[73], overflow[74], zero pad
);

    logic             r_in_valid;
    pcq_pkg::t_item   r_item;
    logic             r_out_valid;
    pcq_pkg::t_result r_res;

    logic                         w_adv;
    logic                         w_fire;
    pcq_pkg::t_result             w_res;
    logic [pcq_pkg::ENTRY_W-1:0]  w_rdata;
    logic [pcq_pkg::ENTRY_W-1:0]  w_entry_out;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.command    <= i_s_tuser;
            r_item.entry_in   <= i_s_tdata[63:0];
            r_item.pin_levels <= i_s_tdata[68:64];
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    pcq_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (r_item),
        .o_res       (w_res),
        .o_rdata     (w_rdata)
    );

    assign w_entry_out = r_res.pop_valid ? w_rdata : '0;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {5'b0, r_res.overflow, r_res.attention_line, r_res.free_space,
                          w_entry_out, r_res.pop_valid};

    `ASSERT_ALWAYS(a_pop_no_drop, i_clk, i_rst_n,
        !(o_m_tvalid && o_m_tdata[0] && o_m_tdata[74]))
    `ASSERT_ALWAYS(a_pop_clears_line, i_clk, i_rst_n,
        !(o_m_tvalid && o_m_tdata[0] && o_m_tdata[73]))
    `ASSERT_ALWAYS(a_drop_when_full, i_clk, i_rst_n,
        !(o_m_tvalid && o_m_tdata[74]) || (o_m_tdata[72:65] == 8'd1))
    `ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_m_tvalid)

endmodule

// File: tb/sv/tb_pin_change_event_queue_core.sv
`timescale 1ns / 1ps
// Testbench for the pin change event queue core: directed and random command streams
module tb_pin_change_event_queue_core;

    localparam int DEPTH       = pcq_pkg::DEPTH_DEFAULT;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 205;
    localparam int MAX_IDLE    = 19;
    localparam int REPORT_MAX  = 10;

    localparam logic [pcq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    typedef struct packed {
        logic                        pop_valid;
        logic [pcq_pkg::ENTRY_W-1:0] entry_out;
        logic [pcq_pkg::FREE_W-1:0]  free_space;
        logic                        attention_line;
        logic                        overflow;
    } t_outcome;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata   = '0;   // entry_in[63:0], pin_levels[68:64], zero pad
    logic [1:0]  i_s_tuser   = '0;   // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [79:0] o_m_tdata;          // pop_valid[0], entry_out[64:1], free_space[72:65],
                                     // attention_line[73], overflow[74], zero pad

    pin_change_event_queue_core #(.DEPTH(DEPTH)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // predicted queue state
    logic [pcq_pkg::ENTRY_W-1:0]   queue_store [DEPTH];
    logic [IDX_W-1:0]              queue_wr    = '0;
    logic [IDX_W-1:0]              queue_rd    = '0;
    logic [pcq_pkg::PIN_COUNT-1:0] last_pins   = '0;
    logic                          line_level  = 1'b1;
    logic [pcq_pkg::PIN_COUNT-1:0] change_mask = '0;

    pcq_pkg::t_item pending_items[$];
    t_outcome       expected_results[$];
    pcq_pkg::t_item in_flight;
    int             errors    = 0;
    int             snd_wait  = 0;
    int             rcv_wait  = 0;
    bit             snd_idle  = 1'b0;
    bit             rcv_idle  = 1'b0;

    initial forever #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [IDX_W-1:0] entries_held();
        return queue_wr - queue_rd;
    endfunction

    function automatic bit enqueue_entry(logic [pcq_pkg::ENTRY_W-1:0] value);
        if (entries_held() == IDX_W'(DEPTH - 1))
            return 1'b0;
        queue_store[queue_wr] = value;
        queue_wr++;
        line_level = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_outcome predict_queue_step(pcq_pkg::t_item it);
        t_outcome                      res;
        logic [pcq_pkg::PIN_COUNT-1:0] changes;
        res     = '0;
        changes = (it.pin_levels ^ last_pins) & change_mask;
        case (it.command)
            pcq_pkg::CMD_PUSH: res.overflow = !enqueue_entry(it.entry_in);
            pcq_pkg::CMD_TICK: begin
                if (changes != '0)
                    res.overflow = !enqueue_entry(
                        pcq_pkg::ENTRY_W'(pcq_pkg::EVENT_CODE)
                        | (pcq_pkg::ENTRY_W'(changes) << pcq_pkg::EVENT_SHIFT));
                last_pins = it.pin_levels;
            end
            pcq_pkg::CMD_POP: begin
                if (queue_wr == queue_rd) begin
                    line_level = 1'b1;
                end else begin
                    res.pop_valid = 1'b1;
                    res.entry_out = queue_store[queue_rd];
                    queue_rd++;
                    line_level = 1'b0;
                end
            end
            default: ;
        endcase
        res.free_space     = pcq_pkg::FREE_W'(DEPTH) - pcq_pkg::FREE_W'(entries_held());
        res.attention_line = line_level;
        return res;
    endfunction

    function automatic pcq_pkg::t_item random_item(t_mix mix);
        pcq_pkg::t_item it;
        int             r;
        int             push_lim;
        int             tick_lim;
        int             pop_lim;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_lim = 45; tick_lim = 75; pop_lim = 95; end
            MIX_DRAIN: begin push_lim = 10; tick_lim = 20; pop_lim = 97; end
            default:   begin push_lim = 35; tick_lim = 55; pop_lim = 95; end
        endcase
        if (r < push_lim)      it.command = pcq_pkg::CMD_PUSH;
        else if (r < tick_lim) it.command = pcq_pkg::CMD_TICK;
        else if (r < pop_lim)  it.command = pcq_pkg::CMD_POP;
        else                   it.command = CMD_NOP;
        it.entry_in   = {$urandom, $urandom};
        it.pin_levels = pcq_pkg::PIN_COUNT'($urandom);
        return it;
    endfunction

    task automatic add_item(logic [pcq_pkg::CMD_W-1:0] cmd,
                            logic [pcq_pkg::ENTRY_W-1:0] entry,
                            logic [pcq_pkg::PIN_COUNT-1:0] pins);
        pcq_pkg::t_item it;
        it.command    = cmd;
        it.entry_in   = entry;
        it.pin_levels = pins;
        pending_items.push_back(it);
    endtask

    // hold until every transaction is sent and answered
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_s_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_change_mask(logic [pcq_pkg::PIN_COUNT-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        change_mask  = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            snd_wait    = 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(predict_queue_step(in_flight));
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (snd_wait > 0) begin
                    snd_wait--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_flight   = pending_items.pop_front();
                    i_s_tdata  <= {3'b000, in_flight.pin_levels, in_flight.entry_in};
                    i_s_tuser  <= in_flight.command;
                    i_s_tvalid <= 1'b1;
                    snd_wait    = snd_idle ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rcv_wait    = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[0], o_m_tdata[64:1], o_m_tdata[72:65],
                       o_m_tdata[73], o_m_tdata[74]};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display({"%0t: unexpected result valid=%0b entry=%h free=%0d",
                                  " attn=%0b ovf=%0b"},
                                 $realtime, got.pop_valid, got.entry_out, got.free_space,
                                 got.attention_line, got.overflow);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  expected valid=%0b entry=%h free=%0d attn=%0b ovf=%0b",
                                     want.pop_valid, want.entry_out, want.free_space,
                                     want.attention_line, want.overflow);
                            $display("  actual   valid=%0b entry=%h free=%0d attn=%0b ovf=%0b",
                                     got.pop_valid, got.entry_out, got.free_space,
                                     got.attention_line, got.overflow);
                        end
                    end
                end
                rcv_wait = rcv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rcv_wait > 0) begin
                rcv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [pcq_pkg::PIN_COUNT-1:0] masks [PHASES];
        t_mix                          mixes [PHASES];
        masks = '{5'h1F, 5'h00, 5'h15, 5'h01, 5'h10, 5'h0A, 5'h1F, 5'h00, 5'h00};
        mixes = '{MIX_FILL, MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_FILL,
                  MIX_DRAIN, MIX_FILL, MIX_EVEN, MIX_DRAIN};
        masks[7] = pcq_pkg::PIN_COUNT'($urandom);
        masks[8] = pcq_pkg::PIN_COUNT'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mask: ticks raise nothing
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(CMD_NOP,           {$urandom, $urandom}, 5'h1F);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h1F);
        add_item(pcq_pkg::CMD_PUSH, '0, '0);
        add_item(pcq_pkg::CMD_PUSH, '1, 5'h1F);
        add_item(pcq_pkg::CMD_PUSH, 64'h5555_5555_5555_5555, 5'h0A);
        add_item(pcq_pkg::CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 5'h15);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h00);
        wait_for_drain();

        write_change_mask(5'h1F);
        snd_idle = 1'b1;
        rcv_idle = 1'b1;
        add_item(pcq_pkg::CMD_TICK, '0, 5'h1F);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h1F);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h00);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h10);
        add_item(pcq_pkg::CMD_TICK, '0, 5'h01);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(pcq_pkg::CMD_POP,  '0, '0);
        add_item(CMD_NOP,           '1, 5'h1F);
        add_item(pcq_pkg::CMD_PUSH, 64'h0123_4567_89AB_CDEF, '0);
        wait_for_drain();

        for (int p = 0; p < PHASES; p++) begin
            write_change_mask(masks[p]);
            snd_idle = p[0];
            rcv_idle = p[1];
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_items.push_back(random_item(mixes[p]));
            wait_for_drain();
        end

        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/pcq_pkg.sv
design/pcq_ram.sv
design/pcq_engine.sv
design/pin_change_event_queue_core.sv
tb/sv/tb_pin_change_event_queue_core.sv
